// ----- design/smpa_pkg.sv -----
// Shared constants, register codes and controller/datapath interface types
// for the multilook power averaging core. No dependencies.
`default_nettype none

package smpa_pkg;

  localparam int MAX_RANGE   = 4096;
  localparam int MAX_LOOKS   = 64;
  localparam int SAMPLE_BITS = 16;

  localparam int RANGE_BITS     = $clog2(MAX_RANGE);        // position counter
  localparam int LOOK_BITS      = $clog2(MAX_LOOKS);        // look counter
  localparam int RANGE_REG_BITS = RANGE_BITS + 1;           // range_samples register
  localparam int LOOKS_REG_BITS = LOOK_BITS + 1;            // looks_count register
  localparam int SQ_BITS        = 2 * SAMPLE_BITS;          // I*I + Q*Q
  localparam int SUM_BITS       = SQ_BITS + LOOK_BITS;      // accumulator
  localparam int VALUE_BITS     = 32;                       // look_value
  localparam int CFG_DATA_BITS  = RANGE_REG_BITS;           // widest register
  localparam int CFG_ADDR_BITS  = 2;

  localparam int IN_DATA_BITS   = 2 * SAMPLE_BITS;
  localparam int OUT_FIELD_BITS = VALUE_BITS + RANGE_BITS;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam int DIV_STEPS  = SUM_BITS;
  localparam int SQRT_STEPS = VALUE_BITS / 2;
  localparam int STEP_BITS  = $clog2(DIV_STEPS);

  localparam logic [CFG_ADDR_BITS-1:0] REG_LOOKS = 2'd0;
  localparam logic [CFG_ADDR_BITS-1:0] REG_RANGE = 2'd1;
  localparam logic [CFG_ADDR_BITS-1:0] REG_AMP   = 2'd2;

  typedef struct packed {
    logic load;       // capture sample, square it, read accumulator
    logic accum;      // add, write back, advance counters
    logic div_step;   // one restoring division bit
    logic sqrt_init;  // seed square root from the average
    logic sqrt_step;  // one square root digit
    logic out_load;   // fill the output register
  } smpa_cmd_t;

  typedef struct packed {
    logic last_look;  // current item closes a look group
    logic amp_mode;   // amplitude output selected
    logic out_free;   // output register can take a new result
  } smpa_status_t;

endpackage

`default_nettype wire

// ----- design/smpa_ctrl.sv -----
// Sequencing state machine of the multilook core: accept, accumulate,
// divide, optional square root, output. Depends on smpa_pkg.
`default_nettype none

module smpa_ctrl
  import smpa_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire smpa_status_t status,
  output smpa_cmd_t         cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_ACC  = 6'b000010,
    S_DIV  = 6'b000100,
    S_SQI  = 6'b001000,
    S_SQRT = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t               state, state_next;
  logic [STEP_BITS-1:0] step, step_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd        = '0;
    s_tready   = 1'b0;
    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_ACC;
        end
      end
      S_ACC: begin
        cmd.accum  = 1'b1;
        step_next  = '0;
        state_next = status.last_look ? S_DIV : S_IDLE;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == STEP_BITS'(DIV_STEPS - 1)) begin
          state_next = status.amp_mode ? S_SQI : S_OUT;
        end
      end
      S_SQI: begin
        cmd.sqrt_init = 1'b1;
        step_next     = '0;
        state_next    = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        step_next     = step + 1'b1;
        if (step == STEP_BITS'(SQRT_STEPS - 1)) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/smpa_dp.sv -----
// Datapath of the multilook core: config registers, counters, line store,
// squarer, bit-serial divider, digit-serial square root, output register.
// Depends on smpa_pkg.
`default_nettype none

module smpa_dp
  import smpa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0]      m_tdata,
  output logic                          m_tlast,
  input  wire smpa_cmd_t                cmd,
  output smpa_status_t                  status
);

  // configuration
  logic [LOOKS_REG_BITS-1:0] looks_count;
  logic [RANGE_REG_BITS-1:0] range_samples;
  logic                      amplitude_mode;

  always_ff @(posedge clk) begin
    if (rst) begin
      looks_count    <= LOOKS_REG_BITS'(1);
      range_samples  <= RANGE_REG_BITS'(MAX_RANGE);
      amplitude_mode <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_LOOKS: looks_count    <= cfg_wdata[LOOKS_REG_BITS-1:0];
        REG_RANGE: range_samples  <= cfg_wdata;
        REG_AMP:   amplitude_mode <= cfg_wdata[0];
        default:   ;
      endcase
    end
  end

  logic [LOOKS_REG_BITS-1:0] nlooks;
  logic [RANGE_REG_BITS-1:0] nrange;

  always_comb begin
    nlooks = looks_count;
    if (looks_count == '0) nlooks = LOOKS_REG_BITS'(1);
    if (looks_count > LOOKS_REG_BITS'(MAX_LOOKS)) nlooks = LOOKS_REG_BITS'(MAX_LOOKS);
    nrange = range_samples;
    if (range_samples == '0) nrange = RANGE_REG_BITS'(1);
    if (range_samples > RANGE_REG_BITS'(MAX_RANGE)) nrange = RANGE_REG_BITS'(MAX_RANGE);
  end

  // counters
  logic [RANGE_BITS-1:0] sample_counter;
  logic [LOOK_BITS-1:0]  look_counter;
  logic                  last_pos, last_look;

  assign last_pos  = ({1'b0, sample_counter} + RANGE_REG_BITS'(1)) >= nrange;
  assign last_look = ({1'b0, look_counter} + LOOKS_REG_BITS'(1)) >= nlooks;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_counter <= '0;
      look_counter   <= '0;
    end else if (cmd.accum) begin
      if (last_pos) begin
        sample_counter <= '0;
        look_counter   <= last_look ? '0 : look_counter + 1'b1;
      end else begin
        sample_counter <= sample_counter + 1'b1;
      end
    end
  end

  // squarer and line store
  logic [SQ_BITS-1:0]  sq_i, sq_q;
  logic [SQ_BITS-1:0]  pwr;
  logic [SUM_BITS-1:0] rd_data, sum;
  logic [SUM_BITS-1:0] power_sums [MAX_RANGE];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sq_i    <= SQ_BITS'($signed(s_tdata[SAMPLE_BITS-1:0]) *
                          $signed(s_tdata[SAMPLE_BITS-1:0]));
      sq_q    <= SQ_BITS'($signed(s_tdata[IN_DATA_BITS-1:SAMPLE_BITS]) *
                          $signed(s_tdata[IN_DATA_BITS-1:SAMPLE_BITS]));
      rd_data <= power_sums[sample_counter];
    end
    if (cmd.accum) begin
      power_sums[sample_counter] <= sum;
    end
  end

  assign pwr = sq_i + sq_q;
  assign sum = (look_counter == '0) ? SUM_BITS'(pwr) : rd_data + SUM_BITS'(pwr);

  // restoring divider, one quotient bit per step
  logic [SUM_BITS-1:0]       quot;
  logic [LOOKS_REG_BITS-1:0] rem;
  logic [LOOKS_REG_BITS:0]   trial;
  logic                      q_bit;
  logic [RANGE_BITS-1:0]     pos_out;
  logic                      last_pos_out;
  logic [VALUE_BITS-1:0]     avg_sat;

  assign trial = {rem, quot[SUM_BITS-1]};
  assign q_bit = trial >= {1'b0, nlooks};

  always_ff @(posedge clk) begin
    if (cmd.accum) begin
      quot         <= sum;
      rem          <= '0;
      pos_out      <= sample_counter;
      last_pos_out <= last_pos;
    end else if (cmd.div_step) begin
      quot <= {quot[SUM_BITS-2:0], q_bit};
      rem  <= q_bit ? LOOKS_REG_BITS'(trial - {1'b0, nlooks})
                    : trial[LOOKS_REG_BITS-1:0];
    end
  end

  assign avg_sat = (|quot[SUM_BITS-1:VALUE_BITS]) ? '1 : quot[VALUE_BITS-1:0];

  // integer square root, two radicand bits per step
  logic [VALUE_BITS-1:0] sr_x, sr_res, sr_bit;
  logic [VALUE_BITS:0]   sr_tmp;
  logic                  sr_ge;

  assign sr_tmp = {1'b0, sr_res} + {1'b0, sr_bit};
  assign sr_ge  = {1'b0, sr_x} >= sr_tmp;

  always_ff @(posedge clk) begin
    if (cmd.sqrt_init) begin
      sr_x   <= avg_sat;
      sr_res <= '0;
      sr_bit <= VALUE_BITS'(1) << (VALUE_BITS - 2);
    end else if (cmd.sqrt_step) begin
      if (sr_ge) begin
        sr_x   <= sr_x - sr_tmp[VALUE_BITS-1:0];
        sr_res <= (sr_res >> 1) + sr_bit;
      end else begin
        sr_res <= sr_res >> 1;
      end
      sr_bit <= sr_bit >> 2;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      m_tdata <= OUT_DATA_BITS'({pos_out, amplitude_mode ? sr_res : avg_sat});
      m_tlast <= last_pos_out;
    end
  end

  assign status.last_look = last_look;
  assign status.amp_mode  = amplitude_mode;
  assign status.out_free  = !m_tvalid || m_tready;

endmodule

`default_nettype wire

// ----- design/sar_multilook_power_average_core.sv -----
// Top level of the multilook power averaging core: joins the controller and
// the datapath. Depends on smpa_pkg, smpa_ctrl and smpa_dp.
//
// Usage:
//  - s_tdata carries one complex sample per transfer (sample_i, sample_q).
//    Samples arrive range position by range position, line by line; the
//    position and look counters run inside and wrap on their own.
//  - m_tdata/m_tlast carry one result on the last look of a group only:
//    the average power floor(sum / looks), or its floor square root in
//    amplitude mode. m_tlast marks the last range position of the line.
//  - Item flow: a sample that produces no result is loaded and accumulated.
//    A result sample then runs the bit-serial divider (one bit of the 38-bit
//    accumulator per cycle), in amplitude mode the square root (two radicand
//    bits per cycle), and loads the output register once that is free.
//  - One sample is in work at a time. A finished result sits in the output
//    register, so the next sample is taken while it waits; a stalled
//    receiver only blocks the core when the next result is ready to load.
//  - The line store (4096 x 38) has no reset and no clearing pass: the
//    first look of a group overwrites each entry.
//  - rst (synchronous) sets looks_count 1, range_samples 4096, power mode,
//    clears both counters and drops m_tvalid.
//  - Configuration writes (cfg_we/cfg_addr/cfg_wdata) must go in while idle (not enforced).
`default_nettype none

module sar_multilook_power_average_core
  import smpa_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst,
  // configuration write port: 0 looks_count, 1 range_samples, 2 amplitude_mode
  input  wire logic                     cfg_we,
  input  wire logic [CFG_ADDR_BITS-1:0] cfg_addr,
  input  wire logic [CFG_DATA_BITS-1:0] cfg_wdata,
  // sample input
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  input  wire logic [IN_DATA_BITS-1:0]  s_tdata,   // [15:0] sample_i, [31:16] sample_q
  // result output
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  output logic [OUT_DATA_BITS-1:0]      m_tdata,   // [31:0] look_value, [43:32] range_position
  output logic                          m_tlast    // line_done
);

  smpa_cmd_t    cmd;
  smpa_status_t status;

  smpa_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .status   (status),
    .cmd      (cmd)
  );

  smpa_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cmd       (cmd),
    .status    (status)
  );

  // one sample in work at a time
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("sample accepted while previous one in work");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> status.out_free)
    else $error("output register overwritten");

  // square root results fit in half the value width
  a_amp_range: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && status.amp_mode) |-> (m_tdata[VALUE_BITS-1:VALUE_BITS/2] == '0))
    else $error("amplitude result out of range");

endmodule

`default_nettype wire
